FILE: design/indexed_sequence_store_top_defines.svh
// assertion macros shared by the indexed sequence store modules
// no dependencies; included by files that carry concurrent assertions
`ifndef INDEXED_SEQUENCE_STORE_TOP_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_TOP_DEFINES_SVH

// condition holds at every clock edge out of reset
`define ISS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ISS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ISS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/iss_pkg.sv
// types and constants of the indexed sequence store
// no dependencies; imported by the controller, datapath and top level
package iss_pkg;

	localparam int POS_W       = 8;
	localparam int VAL_W       = 32;
	localparam int CNT_OUT_W   = 9;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 48;
	localparam int KIND_W      = 2;
	localparam int STATUS_W    = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic rd_capture;
		logic shift_run;
		logic count_dec;
		logic finish;
	} iss_cmd_t;

	// datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  in_range;
		logic  shift_done;
		logic  out_free;
	} iss_stat_t;

endpackage

FILE: design/iss_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module iss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: design/iss_ctrl.sv
// controller state machine of the indexed sequence store
// depends on iss_pkg
module iss_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  iss_pkg::iss_stat_t stat,
	output iss_pkg::iss_cmd_t  cmd
);

	import iss_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		EXEC,
		RD_WAIT,
		SHIFT,
		FINISH
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_comb begin
		cmd            = '0;
		cmd.capture    = ready_q && s_tvalid;
		cmd.exec       = (state_q == EXEC);
		cmd.rd_capture = (state_q == RD_WAIT);
		cmd.shift_run  = (state_q == SHIFT);
		cmd.count_dec  = (state_q == SHIFT) && stat.shift_done;
		cmd.finish     = (state_q == FINISH) && stat.out_free;
	end

	assign s_tready = ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				IDLE: begin
					if (ready_q && s_tvalid) begin
						state_q <= EXEC;
						ready_q <= 1'b0;
					end
				end
				EXEC: begin
					if (stat.kind == KIND_REMOVE && stat.in_range) begin
						state_q <= SHIFT;
					end else if (stat.kind == KIND_READ && stat.in_range) begin
						state_q <= RD_WAIT;
					end else begin
						state_q <= FINISH;
					end
				end
				RD_WAIT: begin
					state_q <= FINISH;
				end
				SHIFT: begin
					if (stat.shift_done) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (stat.out_free) begin
						state_q <= IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

FILE: design/iss_datapath.sv
// datapath of the indexed sequence store: request registers, count, entry ram,
// shift pipeline and result register; depends on iss_pkg, iss_ram and the defines header
`include "indexed_sequence_store_top_defines.svh"

module iss_datapath #(
	parameter int DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  iss_pkg::iss_cmd_t              cmd,
	output iss_pkg::iss_stat_t             stat,
	input  iss_pkg::kind_t                 in_kind,
	input  logic [iss_pkg::POS_W-1:0]      in_position,
	input  logic [iss_pkg::VAL_W-1:0]      in_value,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [iss_pkg::VAL_W-1:0]      out_read_value,
	output iss_pkg::status_t               out_status,
	output logic [iss_pkg::CNT_OUT_W-1:0]  out_entry_count
);

	import iss_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam int OW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

	kind_t            req_kind_q;
	logic [POS_W-1:0] req_pos_q;
	logic [VAL_W-1:0] req_val_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    src_q;
	logic             rvalid_s1;
	logic [AW-1:0]    dst_s1;
	logic             out_valid_q;
	logic [VAL_W-1:0] rd_val_q;
	status_t          status_q;
	logic [CNT_OUT_W-1:0] out_count_q;

	logic [PW-1:0]    pos_ext;
	logic [PW-1:0]    count_ext;
	logic             in_range;
	logic             full;
	logic             more;
	logic             append_wr;
	logic             ram_wr_en;
	logic [AW-1:0]    ram_wr_addr;
	logic [VAL_W-1:0] ram_wr_data;
	logic [AW-1:0]    ram_rd_addr;
	logic [VAL_W-1:0] ram_rd_data;
	logic [OW-1:0]    count_wide;

	assign pos_ext   = PW'(req_pos_q);
	assign count_ext = PW'(count_q);
	assign in_range  = pos_ext < count_ext;
	assign full      = count_q == CW'(DEPTH);
	assign more      = src_q < count_q;
	assign append_wr = cmd.exec && req_kind_q == KIND_APPEND && !full;

	// shift moves entry src-1 <- src, one per cycle, each read in the cycle before its write
	assign ram_wr_en   = append_wr || rvalid_s1;
	assign ram_wr_addr = rvalid_s1 ? dst_s1 : count_q[AW-1:0];
	assign ram_wr_data = rvalid_s1 ? ram_rd_data : req_val_q;
	assign ram_rd_addr = cmd.shift_run ? src_q[AW-1:0] : pos_ext[AW-1:0];

	iss_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_comb begin
		stat            = '0;
		stat.kind       = req_kind_q;
		stat.in_range   = in_range;
		stat.shift_done = !more && !rvalid_s1;
		stat.out_free   = !out_valid_q || out_ready;
	end

	// request payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_kind_q <= in_kind;
			req_pos_q  <= in_position;
			req_val_q  <= in_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (append_wr) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.exec && req_kind_q == KIND_CLEAR) begin
				count_q <= '0;
			end else if (cmd.count_dec) begin
				count_q <= count_q - CW'(1);
			end
			rvalid_s1 <= cmd.shift_run && more;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			src_q <= CW'(pos_ext + PW'(1));
		end else if (cmd.shift_run && more) begin
			src_q <= src_q + CW'(1);
		end
		dst_s1 <= AW'(src_q - CW'(1));
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_val_q <= '1;
			case (req_kind_q)
				KIND_APPEND: status_q <= full ? ST_FULL : ST_DONE;
				KIND_REMOVE: status_q <= in_range ? ST_DONE : ST_RANGE;
				KIND_READ:   status_q <= in_range ? ST_DONE : ST_RANGE;
				KIND_CLEAR:  status_q <= ST_DONE;
				default:     status_q <= ST_DONE;
			endcase
		end else if (cmd.rd_capture) begin
			rd_val_q <= ram_rd_data;
		end
	end

	assign count_wide = OW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_read_value <= rd_val_q;
			out_status     <= status_q;
			out_count_q    <= count_wide[CNT_OUT_W-1:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign out_entry_count = out_count_q;

	`ISS_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "count above depth")
	`ISS_ASSERT_NEXT(a_append_grows, clk, arst_n, append_wr,
		count_q == $past(count_q) + CW'(1), "append did not grow the count")
	`ISS_ASSERT_IMP(a_shift_in_list, clk, arst_n, rvalid_s1,
		CW'(dst_s1) < count_q, "shift write outside the list")
	`ISS_ASSERT_IMP(a_dec_nonempty, clk, arst_n, cmd.count_dec,
		count_q != '0, "removal from an empty list")

endmodule

FILE: design/indexed_sequence_store_top.sv
// top level of the indexed sequence store: stream ports, controller and datapath
// depends on iss_pkg, iss_ctrl, iss_datapath (and through it iss_ram)

// Bounded ordered list of signed 32-bit entries held in one ram of DEPTH words
// with a fill count. Each request on the slave stream carries an operation in
// s_tuser (append, remove at index, read at index, clear) and returns exactly
// one response on the master stream: the value read (all ones unless an
// in-range read), a status in m_tuser (done, index out of range, store full)
// and the entry count after the operation. One request is in flight at a time;
// s_tready drops from acceptance until the response is loaded into the output
// register. An in-range read also waits for the ram's registered read data.
// A remove at index p closes the gap by moving one entry per cycle through
// the ram's single read and write ports, then drains the last move. The
// next request can be taken in the cycle after the response is loaded,
// even if that response still waits for m_tready; a stalled output
// register holds the finished response until it is taken. No clearing pass
// is needed after reset: only entries below the count are ever read.
module indexed_sequence_store_top #(
	parameter int DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [iss_pkg::S_TDATA_W-1:0]  s_tdata,  // position[7:0], value[39:8]
	input  logic [iss_pkg::KIND_W-1:0]     s_tuser,  // kind[1:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [iss_pkg::M_TDATA_W-1:0]  m_tdata,  // read_value[31:0], entry_count[40:32], zeros
	output logic [iss_pkg::STATUS_W-1:0]   m_tuser   // status[1:0]
);

	import iss_pkg::*;

	iss_cmd_t             cmd;
	iss_stat_t            stat;
	logic [VAL_W-1:0]     read_value;
	status_t              status;
	logic [CNT_OUT_W-1:0] entry_count;

	// sequencing: accept, execute, optional read wait or shift loop, load result
	iss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// request unpacking: position in the low byte, value above it
	iss_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_kind         (kind_t'(s_tuser)),
		.in_position     (s_tdata[POS_W-1:0]),
		.in_value        (s_tdata[POS_W +: VAL_W]),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.out_read_value  (read_value),
		.out_status      (status),
		.out_entry_count (entry_count)
	);

	// response packing, padded to whole bytes
	assign m_tdata = {{(M_TDATA_W - VAL_W - CNT_OUT_W){1'b0}}, entry_count, read_value};
	assign m_tuser = status;

endmodule
